[rtl/lob_pkg.sv]
// Shared constants, codes and field widths of the limit order book engine.
package lob_pkg;

   localparam int NUM_PRICES_DEF  = 4096;
   localparam int BUCKET_SIZE_DEF = 64;
   localparam int LEVEL_DEPTH_DEF = 256;

   localparam int OP_W       = 2;
   localparam int PRICE_W    = 12;
   localparam int QTY_W      = 31;
   localparam int POS_W      = 20;
   localparam int STATUS_W   = 2;
   localparam int NOTIONAL_W = 44;
   localparam int SIZE_W     = 16;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 80;

   localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
   localparam logic [OP_W-1:0] OP_CANCEL  = 2'd1;
   localparam logic [OP_W-1:0] OP_EXECUTE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_LEVEL_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CANCEL_BAD = 2'd2;

endpackage

[rtl/limit_order_book_engine.sv]
// Limit order book engine: one-sided book with price-time priority.
//
// Input channel req_*: one transaction per command (add, cancel by rank,
// execute). Result channel rsp_*: exactly one transaction per command, in
// order, carrying status, filled quantity and notional.
// The engine works on one command at a time; req_tready is high while it is
// idle, so a new command is taken even while the previous result waits in
// the output register for rsp_tready. A stalled receiver only holds the
// finished result; the next command then waits at its last step.
// An add ends early when rejected. Cancel skips whole buckets, then whole
// levels, then shifts each order behind the cancelled one inside the level
// (it ends early when the rank is beyond the book). Execute skips empty
// buckets, visits levels in turn, touches orders and updates each level that
// loses orders; it ends early for a zero quantity or an empty book. The level,
// bucket and order memories each have a single read port, one read per step.
// After reset a clearing pass zeroes the level and bucket memories;
// req_tready stays low during it.
module limit_order_book_engine #(
   parameter int NUM_PRICES  = lob_pkg::NUM_PRICES_DEF,
   parameter int BUCKET_SIZE = lob_pkg::BUCKET_SIZE_DEF,
   parameter int LEVEL_DEPTH = lob_pkg::LEVEL_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // op[1:0], price[13:2], quantity[44:14], position[64:45], zero fill
   input  logic [lob_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[1:0], filled[32:2], notional[76:33], zero fill
   output logic [lob_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int PW   = $clog2(NUM_PRICES);
   localparam int DW   = $clog2(LEVEL_DEPTH);
   localparam int CW   = $clog2(LEVEL_DEPTH + 1);
   localparam int NB   = (NUM_PRICES + BUCKET_SIZE - 1) / BUCKET_SIZE;
   localparam int BW   = (NB > 1) ? $clog2(NB) : 1;
   localparam int BCW  = $clog2(BUCKET_SIZE * LEVEL_DEPTH + 1);
   localparam int TW   = $clog2(NUM_PRICES * LEVEL_DEPTH + 1);
   localparam int BBW  = $clog2(BUCKET_SIZE);
   localparam int DSH  = PW + BBW;
   localparam longint RECIP = (64'd1 << DSH) / BUCKET_SIZE;
   localparam int OAW  = PW + DW;
   localparam int PRW  = lob_pkg::SIZE_W + PW;

   localparam logic [4:0] S_CLEAR    = 5'd0;
   localparam logic [4:0] S_IDLE     = 5'd1;
   localparam logic [4:0] S_ADD_RD   = 5'd2;
   localparam logic [4:0] S_ADD_CHK  = 5'd3;
   localparam logic [4:0] S_CN_START = 5'd4;
   localparam logic [4:0] S_CN_BRD   = 5'd5;
   localparam logic [4:0] S_CN_BCHK  = 5'd6;
   localparam logic [4:0] S_CN_LRD   = 5'd7;
   localparam logic [4:0] S_CN_LCHK  = 5'd8;
   localparam logic [4:0] S_CN_SHR   = 5'd9;
   localparam logic [4:0] S_CN_SHW   = 5'd10;
   localparam logic [4:0] S_EX_START = 5'd11;
   localparam logic [4:0] S_EX_BRD   = 5'd12;
   localparam logic [4:0] S_EX_BCHK  = 5'd13;
   localparam logic [4:0] S_EX_LRD   = 5'd14;
   localparam logic [4:0] S_EX_LCHK  = 5'd15;
   localparam logic [4:0] S_EX_ORD   = 5'd16;
   localparam logic [4:0] S_EX_OTK   = 5'd17;
   localparam logic [4:0] S_EX_ACC   = 5'd18;
   localparam logic [4:0] S_EX_NXT   = 5'd19;
   localparam logic [4:0] S_BQ1      = 5'd20;
   localparam logic [4:0] S_BQ2      = 5'd21;
   localparam logic [4:0] S_BKT_RD   = 5'd22;
   localparam logic [4:0] S_BKT_WR   = 5'd23;
   localparam logic [4:0] S_DONE     = 5'd24;

   typedef struct packed {
      logic [DW-1:0] head;
      logic [DW-1:0] tail;
      logic [CW-1:0] cnt;
   } lvl_type;

   // memories
   lvl_type                     lvl_mem [NUM_PRICES];
   logic [BCW-1:0]              bkt_mem [NB];
   logic [lob_pkg::SIZE_W-1:0]  ord_mem [2**OAW];

   lvl_type                     lvl_rdata_ff;
   logic [BCW-1:0]              bkt_rdata_ff;
   logic [lob_pkg::SIZE_W-1:0]  ord_rdata_ff;

   logic                        lvl_we;
   lvl_type                     lvl_wdata;
   logic [PW-1:0]               lvl_waddr;
   logic                        bkt_we;
   logic [BCW-1:0]              bkt_wdata;
   logic [BW-1:0]               bkt_waddr;
   logic                        ord_we;
   logic [lob_pkg::SIZE_W-1:0]  ord_wdata;
   logic [OAW-1:0]              ord_waddr;
   logic [OAW-1:0]              ord_raddr;

   // control and datapath registers
   logic [4:0]                      state_ff, state_in;
   logic [4:0]                      ret_ff, ret_in;
   logic [PW-1:0]                   clr_ff, clr_in;
   logic [PW-1:0]                   p_ff, p_in;
   logic                            pbad_ff, pbad_in;
   logic [BW-1:0]                   bkt_ff, bkt_in;
   logic [lob_pkg::POS_W-1:0]       pos_ff, pos_in;
   logic [lob_pkg::SIZE_W-1:0]      size_ff, size_in;
   logic [lob_pkg::QTY_W-1:0]       want_ff, want_in;
   logic [lob_pkg::QTY_W-1:0]       left_ff, left_in;
   logic [lob_pkg::NOTIONAL_W-1:0]  value_ff, value_in;
   logic [PRW-1:0]                  prod_ff, prod_in;
   logic [DW-1:0]                   head_ff, head_in;
   logic [DW-1:0]                   tail_ff, tail_in;
   logic [CW-1:0]                   cnt_ff, cnt_in;
   logic [DW-1:0]                   k_ff, k_in;
   logic [CW-1:0]                   pops_ff, pops_in;
   logic                            binc_ff, binc_in;
   logic [CW-1:0]                   bamt_ff, bamt_in;
   logic [TW-1:0]                   total_ff, total_in;
   logic [lob_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [lob_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [lob_pkg::QTY_W-1:0]       rsp_filled_ff, rsp_filled_in;
   logic [lob_pkg::NOTIONAL_W-1:0]  rsp_notional_ff, rsp_notional_in;

   // request fields
   logic [lob_pkg::OP_W-1:0]     req_op;
   logic [lob_pkg::PRICE_W-1:0]  req_price;
   logic [lob_pkg::QTY_W-1:0]    req_quantity;
   logic [lob_pkg::POS_W-1:0]    req_position;

   assign req_op       = req_tdata[1:0];
   assign req_price    = req_tdata[13:2];
   assign req_quantity = req_tdata[44:14];
   assign req_position = req_tdata[64:45];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_notional_ff, rsp_filled_ff, rsp_status_ff};

   // ring arithmetic
   logic [DW:0]    ring_sum;
   logic [DW-1:0]  ring_k1;
   logic [DW:0]    ring_sum0;
   logic [DW-1:0]  ring_k0;
   logic [DW-1:0]  head_nx;
   logic [DW-1:0]  tail_pv;

   always_comb begin
      ring_sum  = {1'b0, head_ff} + {1'b0, k_ff} + (DW+1)'(1);
      ring_k1   = (ring_sum >= (DW+1)'(LEVEL_DEPTH)) ?
                  DW'(ring_sum - (DW+1)'(LEVEL_DEPTH)) : DW'(ring_sum);
      ring_sum0 = {1'b0, head_ff} + {1'b0, k_ff};
      ring_k0   = (ring_sum0 >= (DW+1)'(LEVEL_DEPTH)) ?
                  DW'(ring_sum0 - (DW+1)'(LEVEL_DEPTH)) : DW'(ring_sum0);
      head_nx   = (head_ff == DW'(LEVEL_DEPTH - 1)) ? '0 : head_ff + DW'(1);
      tail_pv   = (tail_ff == '0) ? DW'(LEVEL_DEPTH - 1) : tail_ff - DW'(1);
   end

   // bucket quotient helpers
   logic [PW+DSH-1:0]  quo_prod;
   logic [PW:0]        quo_back;
   logic [PW:0]        quo_rem;

   always_comb begin
      quo_prod = (PW+DSH)'(p_ff) * (PW+DSH)'(RECIP);
      quo_back = (PW+1)'(bkt_ff) * (PW+1)'(BUCKET_SIZE);
      quo_rem  = {1'b0, p_ff} - quo_back;
   end

   // execute step
   logic [lob_pkg::SIZE_W-1:0]  take;
   logic                        pop;

   always_comb begin
      pop  = ({15'd0, ord_rdata_ff} <= left_ff);
      take = pop ? ord_rdata_ff : left_ff[lob_pkg::SIZE_W-1:0];
   end

   always_comb begin
      state_in        = state_ff;
      ret_in          = ret_ff;
      clr_in          = clr_ff;
      p_in            = p_ff;
      pbad_in         = pbad_ff;
      bkt_in          = bkt_ff;
      pos_in          = pos_ff;
      size_in         = size_ff;
      want_in         = want_ff;
      left_in         = left_ff;
      value_in        = value_ff;
      prod_in         = prod_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      cnt_in          = cnt_ff;
      k_in            = k_ff;
      pops_in         = pops_ff;
      binc_in         = binc_ff;
      bamt_in         = bamt_ff;
      total_in        = total_ff;
      status_in       = status_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_status_in   = rsp_status_ff;
      rsp_filled_in   = rsp_filled_ff;
      rsp_notional_in = rsp_notional_ff;
      lvl_we          = 1'b0;
      lvl_waddr       = p_ff;
      lvl_wdata       = '{head: head_ff, tail: tail_ff, cnt: cnt_ff};
      bkt_we          = 1'b0;
      bkt_waddr       = bkt_ff;
      bkt_wdata       = binc_ff ? bkt_rdata_ff + BCW'(bamt_ff)
                                : bkt_rdata_ff - BCW'(bamt_ff);
      ord_we          = 1'b0;
      ord_waddr       = {p_ff, head_ff};
      ord_wdata       = size_ff;
      ord_raddr       = {p_ff, head_ff};

      unique case (state_ff)
         S_CLEAR: begin
            lvl_we    = 1'b1;
            lvl_waddr = clr_ff;
            lvl_wdata = '0;
            if (32'(clr_ff) < NB) begin
               bkt_we    = 1'b1;
               bkt_waddr = BW'(clr_ff);
               bkt_wdata = '0;
            end
            clr_in = clr_ff + PW'(1);
            if (clr_ff == PW'(NUM_PRICES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               p_in      = PW'(32'(req_price));
               pbad_in   = (32'(req_price) >= NUM_PRICES);
               pos_in    = req_position;
               size_in   = req_quantity[lob_pkg::SIZE_W-1:0];
               want_in   = (req_op == lob_pkg::OP_EXECUTE) ? req_quantity : '0;
               left_in   = (req_op == lob_pkg::OP_EXECUTE) ? req_quantity : '0;
               value_in  = '0;
               status_in = lob_pkg::ST_OK;
               case (req_op)
                  lob_pkg::OP_ADD:     state_in = S_ADD_RD;
                  lob_pkg::OP_CANCEL:  state_in = S_CN_START;
                  lob_pkg::OP_EXECUTE: state_in = S_EX_START;
                  default:             state_in = S_DONE;
               endcase
            end
         end
         S_ADD_RD: begin
            state_in = S_ADD_CHK;
         end
         S_ADD_CHK: begin
            if (pbad_ff || lvl_rdata_ff.cnt >= CW'(LEVEL_DEPTH)) begin
               status_in = lob_pkg::ST_LEVEL_FULL;
               state_in  = S_DONE;
            end else begin
               ord_we    = 1'b1;
               ord_waddr = {p_ff, lvl_rdata_ff.tail};
               lvl_we    = 1'b1;
               lvl_wdata = '{head: lvl_rdata_ff.head,
                             tail: (lvl_rdata_ff.tail == DW'(LEVEL_DEPTH - 1)) ?
                                   '0 : lvl_rdata_ff.tail + DW'(1),
                             cnt:  lvl_rdata_ff.cnt + CW'(1)};
               total_in  = total_ff + TW'(1);
               binc_in   = 1'b1;
               bamt_in   = CW'(1);
               ret_in    = S_DONE;
               state_in  = S_BQ1;
            end
         end
         S_CN_START: begin
            if (32'(pos_ff) >= 32'(total_ff)) begin
               status_in = lob_pkg::ST_CANCEL_BAD;
               state_in  = S_DONE;
            end else begin
               bkt_in   = '0;
               state_in = S_CN_BRD;
            end
         end
         S_CN_BRD: begin
            state_in = S_CN_BCHK;
         end
         S_CN_BCHK: begin
            if (32'(pos_ff) < 32'(bkt_rdata_ff)) begin
               p_in     = PW'(32'(bkt_ff) * BUCKET_SIZE);
               state_in = S_CN_LRD;
            end else begin
               pos_in   = pos_ff - lob_pkg::POS_W'(bkt_rdata_ff);
               bkt_in   = bkt_ff + BW'(1);
               state_in = S_CN_BRD;
            end
         end
         S_CN_LRD: begin
            state_in = S_CN_LCHK;
         end
         S_CN_LCHK: begin
            if (32'(pos_ff) < 32'(lvl_rdata_ff.cnt)) begin
               head_in  = lvl_rdata_ff.head;
               tail_in  = lvl_rdata_ff.tail;
               cnt_in   = lvl_rdata_ff.cnt;
               k_in     = DW'(pos_ff);
               state_in = S_CN_SHR;
            end else begin
               pos_in   = pos_ff - lob_pkg::POS_W'(lvl_rdata_ff.cnt);
               p_in     = p_ff + PW'(1);
               state_in = S_CN_LRD;
            end
         end
         S_CN_SHR: begin
            ord_raddr = {p_ff, ring_k1};
            if (CW'(k_ff) + CW'(1) < cnt_ff) begin
               state_in = S_CN_SHW;
            end else begin
               lvl_we    = 1'b1;
               lvl_wdata = '{head: head_ff, tail: tail_pv, cnt: cnt_ff - CW'(1)};
               total_in  = total_ff - TW'(1);
               binc_in   = 1'b0;
               bamt_in   = CW'(1);
               ret_in    = S_DONE;
               state_in  = S_BQ1;
            end
         end
         S_CN_SHW: begin
            ord_we    = 1'b1;
            ord_waddr = {p_ff, ring_k0};
            ord_wdata = ord_rdata_ff;
            k_in      = k_ff + DW'(1);
            state_in  = S_CN_SHR;
         end
         S_EX_START: begin
            if (want_ff == '0 || total_ff == '0) begin
               state_in = S_DONE;
            end else begin
               bkt_in   = '0;
               state_in = S_EX_BRD;
            end
         end
         S_EX_BRD: begin
            state_in = S_EX_BCHK;
         end
         S_EX_BCHK: begin
            if (bkt_rdata_ff != '0) begin
               p_in     = PW'(32'(bkt_ff) * BUCKET_SIZE);
               state_in = S_EX_LRD;
            end else begin
               bkt_in   = bkt_ff + BW'(1);
               state_in = S_EX_BRD;
            end
         end
         S_EX_LRD: begin
            state_in = S_EX_LCHK;
         end
         S_EX_LCHK: begin
            head_in  = lvl_rdata_ff.head;
            tail_in  = lvl_rdata_ff.tail;
            cnt_in   = lvl_rdata_ff.cnt;
            pops_in  = '0;
            state_in = S_EX_ORD;
         end
         S_EX_ORD: begin
            if (cnt_ff != '0 && left_ff != '0) begin
               state_in = S_EX_OTK;
            end else begin
               lvl_we = 1'b1;
               if (pops_ff != '0) begin
                  binc_in  = 1'b0;
                  bamt_in  = pops_ff;
                  ret_in   = S_EX_NXT;
                  state_in = S_BQ1;
               end else begin
                  state_in = S_EX_NXT;
               end
            end
         end
         S_EX_OTK: begin
            ord_we    = 1'b1;
            ord_wdata = ord_rdata_ff - take;
            left_in   = left_ff - lob_pkg::QTY_W'(take);
            prod_in   = PRW'(take) * PRW'(p_ff);
            if (pop) begin
               head_in  = head_nx;
               cnt_in   = cnt_ff - CW'(1);
               pops_in  = pops_ff + CW'(1);
               total_in = total_ff - TW'(1);
            end
            state_in = S_EX_ACC;
         end
         S_EX_ACC: begin
            value_in = value_ff + lob_pkg::NOTIONAL_W'(prod_ff);
            state_in = S_EX_ORD;
         end
         S_EX_NXT: begin
            if (left_ff == '0 || total_ff == '0 || p_ff == PW'(NUM_PRICES - 1)) begin
               state_in = S_DONE;
            end else begin
               p_in     = p_ff + PW'(1);
               state_in = S_EX_LRD;
            end
         end
         S_BQ1: begin
            // quotient estimate, low by at most one
            bkt_in   = BW'(quo_prod[PW+DSH-1:DSH]);
            state_in = S_BQ2;
         end
         S_BQ2: begin
            if (quo_rem >= (PW+1)'(BUCKET_SIZE)) begin
               bkt_in = bkt_ff + BW'(1);
            end
            state_in = S_BKT_RD;
         end
         S_BKT_RD: begin
            state_in = S_BKT_WR;
         end
         S_BKT_WR: begin
            bkt_we   = 1'b1;
            state_in = ret_ff;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in    = 1'b1;
               rsp_status_in   = status_ff;
               rsp_filled_in   = want_ff - left_ff;
               rsp_notional_in = value_ff;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (lvl_we) begin
         lvl_mem[lvl_waddr] <= lvl_wdata;
      end
      lvl_rdata_ff <= lvl_mem[p_ff];
   end

   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bkt_mem[bkt_waddr] <= bkt_wdata;
      end
      bkt_rdata_ff <= bkt_mem[bkt_ff];
   end

   always_ff @(posedge clock) begin
      if (ord_we) begin
         ord_mem[ord_waddr] <= ord_wdata;
      end
      ord_rdata_ff <= ord_mem[ord_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff          <= ret_in;
      p_ff            <= p_in;
      pbad_ff         <= pbad_in;
      bkt_ff          <= bkt_in;
      pos_ff          <= pos_in;
      size_ff         <= size_in;
      want_ff         <= want_in;
      left_ff         <= left_in;
      value_ff        <= value_in;
      prod_ff         <= prod_in;
      head_ff         <= head_in;
      tail_ff         <= tail_in;
      cnt_ff          <= cnt_in;
      k_ff            <= k_in;
      pops_ff         <= pops_in;
      binc_ff         <= binc_in;
      bamt_ff         <= bamt_in;
      status_ff       <= status_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_filled_ff   <= rsp_filled_in;
      rsp_notional_ff <= rsp_notional_in;
   end

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= NUM_PRICES * LEVEL_DEPTH)
      else $error("order total exceeds book capacity");

   a_err_no_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != lob_pkg::ST_OK |->
         rsp_filled_ff == '0 && rsp_notional_ff == '0)
      else $error("rejected command reports a fill");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command taken while one is in flight");

endmodule
